@@ rtl/rasc_pkg.sv @@
// ============================================================================
// rasc_pkg
// Shared types, sizes, operation codes and pointer helpers for the
// return-address stack with checkpoint recovery.
// ============================================================================
package rasc_pkg;

    // Storage sizes
    localparam int STACK_DEPTH = 32;
    localparam int LOG_DEPTH   = 64;
    localparam int STK_AW      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int LOG_AW      = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;

    // Field widths fixed by the interface
    localparam int ADDR_W = 64;
    localparam int FUNC_W = 3;
    localparam int SLOT_W = 6;
    localparam int MODE_W = 2;

    // Operation codes
    localparam logic [FUNC_W-1:0] FN_PREDICT = 3'd0;
    localparam logic [FUNC_W-1:0] FN_UPDATE  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_SAVE    = 3'd2;
    localparam logic [FUNC_W-1:0] FN_RESTORE = 3'd3;
    localparam logic [FUNC_W-1:0] FN_LOG     = 3'd4;
    localparam logic [FUNC_W-1:0] FN_FLUSH   = 3'd5;

    // Recovery modes
    localparam logic [MODE_W-1:0] MODE_PTR   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FULL  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WALK  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RESET = MODE_FULL;

    typedef logic [STK_AW-1:0] stk_ptr_t;

    // Input item
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              do_pop;
        logic              do_push;
        logic [ADDR_W-1:0] return_addr;
        logic [SLOT_W-1:0] slot;
    } in_item_t;

    // Result item
    typedef struct packed {
        logic [ADDR_W-1:0] predicted_target;
        logic              error;
    } out_item_t;

    // Branch log entry
    typedef struct packed {
        stk_ptr_t          ptr;
        logic [ADDR_W-1:0] content;
    } log_entry_t;

    // Stack memory access request
    typedef struct packed {
        logic              rd_en;
        stk_ptr_t          rd_addr;
        logic              wr_en;
        stk_ptr_t          wr_addr;
        logic [ADDR_W-1:0] wr_data;
    } stk_req_t;

    // Entry just below the pointer, wrapping from 0 to the last entry
    function automatic stk_ptr_t ptr_below(input stk_ptr_t p);
        return (p == '0) ? STK_AW'(STACK_DEPTH - 1) : STK_AW'(p - 1'b1);
    endfunction

    // Next entry above the pointer, wrapping from the last entry to 0
    function automatic stk_ptr_t ptr_above(input stk_ptr_t p);
        return (p == STK_AW'(STACK_DEPTH - 1)) ? '0 : STK_AW'(p + 1'b1);
    endfunction

endpackage

@@ rtl/return_address_stack_checkpoint_core.sv @@
// ============================================================================
// return_address_stack_checkpoint_core
// Circular return-address stack with fetch checkpoint and branch-log recovery.
// ============================================================================
// Each item takes three steps: accept (stack read at the top pointer and
// branch log read at the slot), execute (one stack write, pointer, checkpoint
// and log updates), and the prediction read of the entry below the new top.
// The single stack read port, used twice per item, sets these steps. A new
// item is accepted once the previous one has reached the output register;
// the result then waits there while the next item runs. Stack entries reset
// to zero via per-entry valid bits, so no clearing pass is needed; branch log
// slots are undefined until logged. The user writes recovery_mode through
// cfg_valid/cfg_ready only while the block is idle; no logic enforces it.
module return_address_stack_checkpoint_core
    import rasc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  in_item_t          in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output out_item_t         out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [MODE_W-1:0] cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_READ = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [MODE_W-1:0] mode_reg;
    in_item_t          item_reg;
    stk_ptr_t          top_reg, top_next;
    stk_ptr_t          saved_ptr_reg, saved_ptr_next;
    logic [ADDR_W-1:0] saved_content_reg, saved_content_next;
    logic              err_reg, err_next;
    logic              out_valid_reg;
    out_item_t         out_data_reg;

    log_entry_t        log_mem [LOG_DEPTH];
    log_entry_t        log_q_reg;
    logic              log_we;

    stk_req_t          stk_req;
    logic [ADDR_W-1:0] stk_rd_data;

    logic              in_accept;
    logic              out_busy;
    logic              slot_ok;
    logic              mode_hi;
    stk_ptr_t          flush_ptr;

    // Handshake
    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_busy  = out_valid_reg && out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Decode helpers
    assign slot_ok   = (32'(item_reg.slot) < 32'(LOG_DEPTH));
    assign mode_hi   = (mode_reg != MODE_PTR) && (mode_reg != MODE_FULL);
    assign flush_ptr = (32'(log_q_reg.ptr) >= 32'(STACK_DEPTH)) ? '0 : log_q_reg.ptr;

    // Stack memory
    rasc_stack u_stack (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (stk_req),
        .rd_data (stk_rd_data)
    );

    // Branch log memory: written in execute, read on accept
    always_ff @(posedge clk)
    begin
        if (log_we)
        begin
            log_mem[item_reg.slot[LOG_AW-1:0]] <= '{ptr: saved_ptr_reg,
                                                    content: saved_content_reg};
        end
        if (in_accept)
        begin
            log_q_reg <= log_mem[in_data.slot[LOG_AW-1:0]];
        end
    end

    // Accept read and execute step: pointer, checkpoint, log, stack write and read
    always_comb
    begin
        top_next           = top_reg;
        saved_ptr_next     = saved_ptr_reg;
        saved_content_next = saved_content_reg;
        err_next           = err_reg;
        log_we             = 1'b0;
        stk_req            = '0;
        stk_req.wr_data    = item_reg.return_addr;

        if (state_reg == S_IDLE)
        begin
            stk_req.rd_en   = in_accept;
            stk_req.rd_addr = top_reg;
        end
        else if (state_reg == S_EXEC)
        begin
            err_next = 1'b0;
            case (item_reg.func)
                FN_UPDATE:
                begin
                    if (item_reg.do_pop && !item_reg.do_push)
                    begin
                        top_next = ptr_below(top_reg);
                    end
                    else if (item_reg.do_push && !item_reg.do_pop)
                    begin
                        stk_req.wr_en   = 1'b1;
                        stk_req.wr_addr = top_reg;
                        stk_req.wr_data = item_reg.return_addr;
                        top_next        = ptr_above(top_reg);
                    end
                end
                FN_SAVE:
                begin
                    saved_ptr_next     = top_reg;
                    saved_content_next = stk_rd_data;
                end
                FN_RESTORE:
                begin
                    if (mode_reg == MODE_PTR)
                    begin
                        top_next = saved_ptr_reg;
                    end
                    else if (mode_reg == MODE_FULL || mode_reg == MODE_WALK)
                    begin
                        top_next        = saved_ptr_reg;
                        stk_req.wr_en   = 1'b1;
                        stk_req.wr_addr = saved_ptr_reg;
                        stk_req.wr_data = saved_content_reg;
                    end
                end
                FN_LOG:
                begin
                    log_we = slot_ok;
                end
                FN_FLUSH:
                begin
                    if (mode_hi)
                    begin
                        err_next = 1'b1;
                    end
                    else if (slot_ok)
                    begin
                        top_next = flush_ptr;
                        if (mode_reg == MODE_FULL)
                        begin
                            stk_req.wr_en   = 1'b1;
                            stk_req.wr_addr = flush_ptr;
                            stk_req.wr_data = log_q_reg.content;
                        end
                    end
                end
                default:
                begin
                end
            endcase
            // prediction read below the new top
            stk_req.rd_en   = 1'b1;
            stk_req.rd_addr = ptr_below(top_next);
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_accept) state_next = S_EXEC;
            S_EXEC:  state_next = S_READ;
            S_READ:  if (!out_busy) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Item and result capture
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_reg <= in_data;
        end
        if (state_reg == S_READ && !out_busy)
        begin
            out_data_reg <= '{predicted_target: stk_rd_data, error: err_reg};
        end
    end

    // Control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            mode_reg          <= MODE_RESET;
            top_reg           <= '0;
            saved_ptr_reg     <= '0;
            saved_content_reg <= '0;
            err_reg           <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            top_reg           <= top_next;
            saved_ptr_reg     <= saved_ptr_next;
            saved_content_reg <= saved_content_next;
            err_reg           <= err_next;
            if (cfg_valid && cfg_ready)
            begin
                mode_reg <= cfg_data;
            end
            if (state_reg == S_READ && !out_busy)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Assertions
    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == S_EXEC))
        else $error("accepted item did not enter execute");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ && !out_busy) |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("finished item not moved to output register");

    a_write_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (stk_req.wr_en || log_we) |-> (state_reg == S_EXEC))
        else $error("memory write outside execute step");

    a_error_source: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && err_next) |-> (item_reg.func == FN_FLUSH && mode_hi))
        else $error("error raised for an item that is not an unsupported flush");

endmodule

@@ rtl/rasc_stack.sv @@
// ============================================================================
// rasc_stack
// Return-address store: one write and one registered read per cycle, per-entry
// valid bits so unwritten entries read as zero, and write-to-read forwarding.
// ============================================================================
module rasc_stack
    import rasc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  stk_req_t          req,
    output logic [ADDR_W-1:0] rd_data
);

    logic [ADDR_W-1:0]      mem [STACK_DEPTH];
    logic [ADDR_W-1:0]      mem_q_reg;
    logic [STACK_DEPTH-1:0] valid_reg;
    logic                   hit_valid_reg;
    logic                   fwd_reg;
    logic [ADDR_W-1:0]      fwd_data_reg;

    // Storage array and registered read
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            mem_q_reg    <= mem[req.rd_addr];
            fwd_data_reg <= req.wr_data;
        end
    end

    // Valid bits and read-side flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            hit_valid_reg <= 1'b0;
            fwd_reg       <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                hit_valid_reg <= valid_reg[req.rd_addr];
                fwd_reg       <= req.wr_en && (req.wr_addr == req.rd_addr);
            end
        end
    end

    // Same-cycle write wins, then stored data, else reset value
    assign rd_data = fwd_reg       ? fwd_data_reg :
                     hit_valid_reg ? mem_q_reg    : '0;

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the return-address stack with checkpoint recovery.
// Every accepted operation is run through a local copy of the stack, the
// checkpoint and the branch log, and the predicted result is queued.
// Each returned item is checked against the oldest queued prediction. Stimulus
// is a short directed set, then random call/return traffic with checkpoints
// and recoveries under every recovery mode. Both sides stall at random.
// ----------------------------------------------------------------------------
module tb;
    import rasc_pkg::*;

    // Codes left unused by the block; they must behave like a predict
    localparam logic [FUNC_W-1:0] FN_SPARE_A = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SPARE_B = 3'd7;

    localparam int CLK_PERIOD  = 12;
    localparam int RESET_TICKS = 8;
    localparam int SETTLE      = 8;
    localparam int MAX_CYCLES  = 400000;
    localparam int PHASE_OPS   = 95;

    // DUT ports
    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    in_item_t          in_data   = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    out_item_t         out_data;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [MODE_W-1:0] cfg_data  = MODE_RESET;

    // Shadow of the block state
    logic [ADDR_W-1:0] shadow_stack [STACK_DEPTH];
    stk_ptr_t          shadow_top;
    stk_ptr_t          shadow_saved_ptr;
    logic [ADDR_W-1:0] shadow_saved_entry;
    stk_ptr_t          shadow_log_ptr [LOG_DEPTH];
    logic [ADDR_W-1:0] shadow_log_entry [LOG_DEPTH];
    logic [MODE_W-1:0] shadow_mode;

    // Traffic bookkeeping
    in_item_t  op_queue [$];
    out_item_t pending_targets [$];
    bit        slot_logged [LOG_DEPTH];
    int        logged_slots [$];
    int        ops_sent      = 0;
    int        ops_taken     = 0;
    int        targets_seen  = 0;
    int        flush_errors  = 0;
    int        err_cnt       = 0;
    int        cycle_cnt     = 0;
    int        modes_written = 0;
    int        func_hits [8];
    int        send_gap      = 0;
    int        stall_left    = 0;
    int        held_at       = -1;
    bit        drain_hold    = 1'b0;
    bit        calm          = 1'b0;

    return_address_stack_checkpoint_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Clock
    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > MAX_CYCLES)
        begin
            $display("tb: timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, pending_targets.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Circular step down, last entry below entry 0
    function automatic stk_ptr_t entry_below(input stk_ptr_t p);
        return (p == '0) ? stk_ptr_t'(STACK_DEPTH - 1) : stk_ptr_t'(p - 1'b1);
    endfunction

    // Apply one operation to the shadow state and return the predicted result
    function automatic out_item_t ras_next(input in_item_t op);
        out_item_t res;
        res.error = 1'b0;
        case (op.func)
            FN_UPDATE:
            begin
                if (op.do_pop && !op.do_push)
                begin
                    shadow_top = entry_below(shadow_top);
                end
                else if (op.do_push && !op.do_pop)
                begin
                    shadow_stack[shadow_top] = op.return_addr;
                    shadow_top = (shadow_top == stk_ptr_t'(STACK_DEPTH - 1)) ?
                                 '0 : stk_ptr_t'(shadow_top + 1'b1);
                end
            end
            FN_SAVE:
            begin
                shadow_saved_ptr   = shadow_top;
                shadow_saved_entry = shadow_stack[shadow_top];
            end
            FN_RESTORE:
            begin
                if (shadow_mode == MODE_PTR)
                begin
                    shadow_top = shadow_saved_ptr;
                end
                else if (shadow_mode == MODE_FULL || shadow_mode == MODE_WALK)
                begin
                    shadow_top = shadow_saved_ptr;
                    shadow_stack[shadow_top] = shadow_saved_entry;
                end
            end
            FN_LOG:
            begin
                shadow_log_ptr[op.slot]   = shadow_saved_ptr;
                shadow_log_entry[op.slot] = shadow_saved_entry;
            end
            FN_FLUSH:
            begin
                // walk mode cannot recover from the log
                if (shadow_mode >= MODE_WALK)
                begin
                    res.error = 1'b1;
                end
                else
                begin
                    shadow_top = shadow_log_ptr[op.slot];
                    if (shadow_mode == MODE_FULL)
                        shadow_stack[shadow_top] = shadow_log_entry[op.slot];
                end
            end
            default:
            begin
            end
        endcase
        res.predicted_target = shadow_stack[entry_below(shadow_top)];
        return res;
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Input acceptance: predict at the edge that takes the item
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            pending_targets.push_back(ras_next(in_data));
            func_hits[in_data.func]++;
            ops_taken++;
        end
    end

    // Input driver
    always @(negedge clk)
    begin
        logic     nxt_valid;
        in_item_t nxt_data;
        nxt_valid = in_valid;
        nxt_data  = in_data;
        if (rst_n)
        begin
            if (in_valid && ops_sent == ops_taken)
                nxt_valid = 1'b0;
            if (!nxt_valid)
            begin
                if (drain_hold)
                begin
                    // hold off until everything sent has come back
                    if (pending_targets.size() == 0 && ops_sent == ops_taken)
                        drain_hold = 1'b0;
                end
                else if (send_gap > 0)
                begin
                    send_gap--;
                end
                else if (op_queue.size() > 0)
                begin
                    if (ops_sent != held_at &&
                        ((ops_sent % 97) == 50 || $urandom_range(0, 199) == 0))
                    begin
                        drain_hold = 1'b1;
                        held_at    = ops_sent;
                    end
                    else
                    begin
                        nxt_data  = op_queue.pop_front();
                        nxt_valid = 1'b1;
                        ops_sent++;
                        send_gap  = pick_gap();
                    end
                end
            end
        end
        in_valid <= nxt_valid;
        in_data  <= nxt_data;
    end

    // Output stall driver
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            out_stall  <= 1'b0;
            stall_left = pick_gap();
        end
    end

    // Output monitor
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_targets.size() == 0)
            begin
                $display("%0t: unexpected item target=%h error=%b", $time,
                         out_data.predicted_target, out_data.error);
                err_cnt++;
            end
            else
            begin
                want = pending_targets.pop_front();
                targets_seen++;
                if (out_data.predicted_target !== want.predicted_target)
                begin
                    $display("%0t: predicted_target expected %h actual %h", $time,
                             want.predicted_target, out_data.predicted_target);
                    err_cnt++;
                end
                if (out_data.error !== want.error)
                begin
                    $display("%0t: error expected %b actual %b", $time,
                             want.error, out_data.error);
                    err_cnt++;
                end
                if (want.error)
                    flush_errors++;
            end
        end
    end

    // Queue one operation; flushes only ever use slots already logged
    task automatic queue_op(input logic [FUNC_W-1:0] fn, input logic pop,
                            input logic push, input logic [ADDR_W-1:0] addr,
                            input logic [SLOT_W-1:0] slot);
        in_item_t op;
        op.func        = fn;
        op.do_pop      = pop;
        op.do_push     = push;
        op.return_addr = addr;
        op.slot        = slot;
        if (fn == FN_LOG && !slot_logged[slot])
        begin
            slot_logged[slot] = 1'b1;
            logged_slots.push_back(int'(slot));
        end
        op_queue.push_back(op);
    endtask

    // Wait for the block to go quiet
    task automatic wait_idle();
        while (op_queue.size() != 0 || ops_sent != ops_taken ||
               pending_targets.size() != 0 || in_valid)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // Write the recovery mode while idle
    task automatic write_mode(input logic [MODE_W-1:0] m);
        wait_idle();
        cfg_data  <= m;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        shadow_mode = m;
        modes_written++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Random traffic: mostly calls, returns and checkpoint traffic
    task automatic queue_random(input int n);
        int                r;
        logic [FUNC_W-1:0] fn;
        logic              pop;
        logic              push;
        logic [ADDR_W-1:0] addr;
        logic [SLOT_W-1:0] slot;
        for (int i = 0; i < n; i++)
        begin
            r    = $urandom_range(0, 99);
            addr = {$urandom, $urandom};
            if ($urandom_range(0, 15) == 0)
                addr = $urandom_range(0, 1) ? '1 : '0;
            pop  = 1'($urandom_range(0, 1));
            push = 1'($urandom_range(0, 1));
            slot = SLOT_W'($urandom_range(0, LOG_DEPTH - 1));
            if (r < 30)
            begin
                fn = FN_UPDATE; pop = 1'b0; push = 1'b1;
            end
            else if (r < 50)
            begin
                fn = FN_UPDATE; pop = 1'b1; push = 1'b0;
            end
            else if (r < 58)
                fn = FN_PREDICT;
            else if (r < 68)
                fn = FN_SAVE;
            else if (r < 76)
                fn = FN_RESTORE;
            else if (r < 86)
                fn = FN_LOG;
            else if (r < 94)
            begin
                if (logged_slots.size() == 0)
                    fn = FN_LOG;
                else
                begin
                    fn   = FN_FLUSH;
                    slot = SLOT_W'(logged_slots[$urandom_range(0, logged_slots.size() - 1)]);
                end
            end
            else if (r < 97)
            begin
                // malformed update: both or neither
                fn   = FN_UPDATE;
                push = pop;
            end
            else
                fn = $urandom_range(0, 1) ? FN_SPARE_A : FN_SPARE_B;
            queue_op(fn, pop, push, addr, slot);
        end
    endtask

    // Main sequence
    initial
    begin
        logic [MODE_W-1:0] phase_mode [7];
        phase_mode = '{MODE_FULL, MODE_PTR, MODE_WALK, MODE_FULL,
                       MODE_PTR, MODE_WALK, MODE_FULL};
        for (int i = 0; i < STACK_DEPTH; i++)
            shadow_stack[i] = '0;
        for (int i = 0; i < LOG_DEPTH; i++)
        begin
            shadow_log_ptr[i]   = '0;
            shadow_log_entry[i] = '0;
            slot_logged[i]      = 1'b0;
        end
        for (int i = 0; i < 8; i++)
            func_hits[i] = 0;
        shadow_top         = '0;
        shadow_saved_ptr   = '0;
        shadow_saved_entry = '0;
        shadow_mode        = MODE_RESET;

        repeat (RESET_TICKS) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: reset mode first
        queue_op(FN_PREDICT, 1'b0, 1'b0, '0, '0);
        queue_op(FN_UPDATE, 1'b1, 1'b0, '0, '0);        // pop wraps to last entry
        queue_op(FN_UPDATE, 1'b0, 1'b1, '1, '0);        // push at last entry wraps
        queue_op(FN_UPDATE, 1'b0, 1'b1, 64'h0123_4567_89ab_cdef, '1);
        queue_op(FN_UPDATE, 1'b1, 1'b1, '1, '0);        // pop and push: no change
        queue_op(FN_UPDATE, 1'b0, 1'b0, '1, '1);        // neither: no change
        queue_op(FN_SAVE, 1'b1, 1'b1, '1, '1);
        queue_op(FN_UPDATE, 1'b0, 1'b1, 64'ha5a5_5a5a_f00f_0ff0, '0);
        queue_op(FN_UPDATE, 1'b0, 1'b1, 64'h8000_0000_0000_0001, '0);
        queue_op(FN_RESTORE, 1'b0, 1'b0, '0, '0);
        queue_op(FN_LOG, 1'b0, 1'b0, '0, '0);
        queue_op(FN_LOG, 1'b1, 1'b1, '1, '1);
        queue_op(FN_SPARE_A, 1'b1, 1'b1, '1, '1);
        queue_op(FN_SPARE_B, 1'b0, 1'b0, '0, '0);
        queue_op(FN_UPDATE, 1'b0, 1'b1, 64'hdead_beef_cafe_f00d, '0);
        queue_op(FN_FLUSH, 1'b0, 1'b0, '0, '1);
        queue_op(FN_UPDATE, 1'b1, 1'b0, '0, '0);
        queue_op(FN_FLUSH, 1'b1, 1'b1, '1, '0);

        // Directed: pointer-only recovery
        write_mode(MODE_PTR);
        queue_op(FN_UPDATE, 1'b0, 1'b1, 64'h1111_2222_3333_4444, '0);
        queue_op(FN_RESTORE, 1'b0, 1'b0, '0, '0);
        queue_op(FN_UPDATE, 1'b0, 1'b1, 64'h5555_6666_7777_8888, '0);
        queue_op(FN_FLUSH, 1'b0, 1'b0, '0, '1);

        // Directed: walk mode, flush flags an error
        write_mode(MODE_WALK);
        queue_op(FN_UPDATE, 1'b0, 1'b1, 64'h9999_aaaa_bbbb_cccc, '0);
        queue_op(FN_RESTORE, 1'b0, 1'b0, '0, '0);
        queue_op(FN_FLUSH, 1'b0, 1'b0, '0, '0);

        // Random phases, one recovery mode each
        for (int ph = 0; ph < 7; ph++)
        begin
            write_mode(phase_mode[ph]);
            calm = (ph == 3);
            queue_random(PHASE_OPS);
        end

        wait_idle();
        $display("tb: %0d items (%0d flush, %0d restore, %0d log), %0d mode writes",
                 ops_taken, func_hits[FN_FLUSH], func_hits[FN_RESTORE],
                 func_hits[FN_LOG], modes_written);
        $display("tb: %0d results checked, %0d walk-mode flush errors seen",
                 targets_seen, flush_errors);
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/rasc_pkg.sv
rtl/rasc_stack.sv
rtl/return_address_stack_checkpoint_core.sv
sim/tb.sv
